FILE: rtl/ppsa_pkg.sv
// Shared types and constants of the priority scheduler with aging.
// Used by the controller, the datapath and the top level; no dependencies.
package ppsa_pkg;

    // Default sizing of the slot table and the time counter
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Fixed field widths of the item ports
    localparam int SLOT_BITS = 4;
    localparam int FIELD_BITS = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_BITS = 5;
    localparam int SUM_BITS = 32;

    // Selections before one step of aging
    localparam logic [1:0] AGING_LIMIT = 2'd2;

    // Item action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // One task slot as held in the table memory
    typedef struct packed {
        logic [FIELD_BITS-1:0] arrival;
        logic [FIELD_BITS-1:0] remaining;
        logic [FIELD_BITS-1:0] original;
        logic [PRIO_BITS-1:0]  priority_lvl;
        logic [1:0]            sel_count;
    } t_entry;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // load transfer accepted this cycle
        logic tick_start;  // tick transfer accepted this cycle
        logic scan;        // issue a table read at the scan index
        logic update;      // write back the pick and advance time
        logic finish;      // fold completion into the counters
        logic emit;        // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;   // scan index points at the last slot
    } t_stat;

endpackage

FILE: rtl/preemptive_priority_scheduler_aging_core.sv
// Top level of the preemptive priority scheduler with aging.
// Joins ppsa_ctrl and ppsa_datapath; depends on ppsa_pkg.
//
//  Channel   Handshake                 Payload
//  input     i_in_valid / o_in_ready   i_action, i_slot, i_arrival, i_run_length,
//                                      i_start_priority
//  output    o_out_valid / i_out_ready o_chosen_*, o_start_time, o_finished,
//                                      o_turnaround, o_waiting, o_all_done, o_total_*
//  config    i_cfg_we                  i_cfg_wdata (processes in use)
//
// A load result goes to the emit step straight after its transfer in; a tick
// result first runs the scan, which reads one table slot per cycle through the
// single memory read port, then the flush, update and finish steps.
// One item is in work at a time; o_in_ready is high only while idle.
// The output register holds a result until taken; a new result waits in the
// emit step while the previous one is still held.
// Reset is synchronous, active low, and clears control state and counters.
module preemptive_priority_scheduler_aging_core
    import ppsa_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [FIELD_BITS-1:0] i_arrival,
    input  logic [FIELD_BITS-1:0] i_run_length,
    input  logic [PRIO_BITS-1:0]  i_start_priority,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_chosen_valid,
    output logic [SLOT_BITS-1:0]  o_chosen_slot,
    output logic [PRIO_BITS-1:0]  o_chosen_priority,
    output logic [FIELD_BITS-1:0] o_start_time,
    output logic                  o_finished,
    output logic [FIELD_BITS-1:0] o_turnaround,
    output logic [FIELD_BITS-1:0] o_waiting,
    output logic                  o_all_done,
    output logic [SUM_BITS-1:0]   o_total_turnaround,
    output logic [SUM_BITS-1:0]   o_total_waiting,
    input  logic                  i_cfg_we,
    input  logic [CNT_BITS-1:0]   i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencing
    ppsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Table, arithmetic and output register
    ppsa_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_slot             (i_slot),
        .i_arrival          (i_arrival),
        .i_run_length       (i_run_length),
        .i_start_priority   (i_start_priority),
        .o_chosen_valid     (o_chosen_valid),
        .o_chosen_slot      (o_chosen_slot),
        .o_chosen_priority  (o_chosen_priority),
        .o_start_time       (o_start_time),
        .o_finished         (o_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_all_done         (o_all_done),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting)
    );

endmodule

FILE: rtl/ppsa_ctrl.sv
// Sequencing controller of the priority scheduler: accept, scan, update, emit.
// Depends on ppsa_pkg for the command and status structs.
module ppsa_ctrl
    import ppsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_action,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE,
        ST_FINISH,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   emit_ok;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign emit_ok     = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // Decode commands from the current state
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = accept && (i_action == ACT_LOAD);
        o_cmd.tick_start = accept && (i_action == ACT_TICK);
        o_cmd.scan       = (r_state == ST_SCAN);
        o_cmd.update     = (r_state == ST_UPDATE);
        o_cmd.finish     = (r_state == ST_FINISH);
        o_cmd.emit       = emit_ok;
    end

    // Next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_action == ACT_TICK) ? ST_SCAN : ST_EMIT;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_ok) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/ppsa_datapath.sv
// Datapath of the priority scheduler: slot table memory, scan compare,
// aging and completion arithmetic, counters and the output register.
// Depends on ppsa_pkg for the entry type and the command/status structs.
module ppsa_datapath
    import ppsa_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CNT_BITS-1:0]   i_cfg_wdata,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [FIELD_BITS-1:0] i_arrival,
    input  logic [FIELD_BITS-1:0] i_run_length,
    input  logic [PRIO_BITS-1:0]  i_start_priority,
    output logic                  o_chosen_valid,
    output logic [SLOT_BITS-1:0]  o_chosen_slot,
    output logic [PRIO_BITS-1:0]  o_chosen_priority,
    output logic [FIELD_BITS-1:0] o_start_time,
    output logic                  o_finished,
    output logic [FIELD_BITS-1:0] o_turnaround,
    output logic [FIELD_BITS-1:0] o_waiting,
    output logic                  o_all_done,
    output logic [SUM_BITS-1:0]   o_total_turnaround,
    output logic [SUM_BITS-1:0]   o_total_waiting
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CW     = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
    localparam logic [CW-1:0] SAT16 = CW'({FIELD_BITS{1'b1}});

    // Slot table and per-slot loaded flags
    t_entry               r_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_loaded;

    // Scan pipeline
    logic [SLOT_W-1:0]    r_idx;
    t_entry               r_rd_data;
    logic                 r_rd_loaded;
    logic                 r_rd_live;
    logic [SLOT_W-1:0]    r_rd_idx;

    // Best candidate so far
    logic                 r_found;
    t_entry               r_best;
    logic [SLOT_W-1:0]    r_best_idx;

    // Scheduler state
    logic [TIME_BITS-1:0] r_time;
    logic [CNT_BITS-1:0]  r_done_cnt;
    logic [SUM_BITS-1:0]  r_sum_ta;
    logic [SUM_BITS-1:0]  r_sum_wt;
    logic [CNT_BITS-1:0]  r_piu;

    // Result of the item in flight
    logic                  r_res_chosen;
    logic [SLOT_BITS-1:0]  r_res_slot;
    logic [PRIO_BITS-1:0]  r_res_prio;
    logic [FIELD_BITS-1:0] r_res_start;
    logic                  r_res_fin;
    logic [FIELD_BITS-1:0] r_res_ta;
    logic [FIELD_BITS-1:0] r_res_wt;

    logic                  slot_ok;
    t_entry                load_entry;
    t_entry                aged_entry;
    logic                  cand_ready;
    logic                  cand_better;
    logic [TIME_BITS-1:0]  time_next;
    logic [CW-1:0]         time_ext;
    logic [CW-1:0]         done_at;
    logic [CW-1:0]         ta_raw;
    logic [CW-1:0]         wt_raw;
    logic [FIELD_BITS-1:0] ta_sat;
    logic [FIELD_BITS-1:0] wt_sat;
    logic [FIELD_BITS-1:0] start_sat;
    logic [SUM_BITS:0]     sum_ta_wide;
    logic [SUM_BITS:0]     sum_wt_wide;

    assign slot_ok = (int'(i_slot) < MAX_TASKS);
    assign o_stat.scan_last = (r_idx == SLOT_W'(MAX_TASKS - 1));

    // Build the entry written by a load
    always_comb begin
        load_entry.arrival      = i_arrival;
        load_entry.remaining    = i_run_length;
        load_entry.original     = i_run_length;
        load_entry.priority_lvl = i_start_priority;
        load_entry.sel_count    = 2'd0;
    end

    // Age the pick: one unit of work done, priority drops every third run
    always_comb begin
        aged_entry           = r_best;
        aged_entry.remaining = r_best.remaining - FIELD_BITS'(1);
        if (r_best.sel_count < AGING_LIMIT) begin
            aged_entry.sel_count = r_best.sel_count + 2'd1;
        end else begin
            aged_entry.sel_count = 2'd0;
            if (r_best.priority_lvl != '0) begin
                aged_entry.priority_lvl = r_best.priority_lvl - PRIO_BITS'(1);
            end
        end
    end

    // Compare the slot just read against the best so far
    always_comb begin
        cand_ready  = r_rd_live && r_rd_loaded && (r_rd_data.remaining != '0) &&
                      (CW'(r_rd_data.arrival) <= CW'(r_time));
        cand_better = !r_found ||
                      (r_rd_data.priority_lvl > r_best.priority_lvl) ||
                      ((r_rd_data.priority_lvl == r_best.priority_lvl) &&
                       (r_rd_data.arrival < r_best.arrival));
    end

    // Time and completion arithmetic
    always_comb begin
        time_next = (r_time == '1) ? r_time : r_time + TIME_BITS'(1);
        time_ext  = CW'(r_time);
        done_at   = CW'(time_next);
        ta_raw    = done_at - CW'(r_best.arrival);
        wt_raw    = (ta_raw > CW'(r_best.original)) ? ta_raw - CW'(r_best.original) : '0;
        ta_sat    = (ta_raw > SAT16) ? '1 : ta_raw[FIELD_BITS-1:0];
        wt_sat    = (wt_raw > SAT16) ? '1 : wt_raw[FIELD_BITS-1:0];
        start_sat = (time_ext > SAT16) ? '1 : time_ext[FIELD_BITS-1:0];
        sum_ta_wide = {1'b0, r_sum_ta} + (SUM_BITS + 1)'(r_res_ta);
        sum_wt_wide = {1'b0, r_sum_wt} + (SUM_BITS + 1)'(r_res_wt);
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            r_mem[SLOT_W'(i_slot)] <= load_entry;
        end else if (i_cmd.update && r_found) begin
            r_mem[r_best_idx] <= aged_entry;
        end
        r_rd_data <= r_mem[r_idx];
        r_rd_idx  <= r_idx;
    end

    // Control state: loaded flags, scan pipeline, counters, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_idx       <= '0;
            r_rd_loaded <= 1'b0;
            r_rd_live   <= 1'b0;
            r_found     <= 1'b0;
            r_time      <= '0;
            r_done_cnt  <= '0;
            r_sum_ta    <= '0;
            r_sum_wt    <= '0;
            r_piu       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_piu <= i_cfg_wdata;
            end
            if (i_cmd.load && slot_ok) begin
                r_loaded[SLOT_W'(i_slot)] <= 1'b1;
            end
            // Advance the scan index and track the read stage
            if (i_cmd.tick_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            r_rd_live   <= i_cmd.scan;
            r_rd_loaded <= r_loaded[r_idx];
            if (i_cmd.tick_start) begin
                r_found <= 1'b0;
            end else if (cand_ready && cand_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.update) begin
                r_time <= time_next;
            end
            // Fold a completion into the saturating counters
            if (i_cmd.finish && r_res_fin) begin
                if (r_done_cnt != '1) begin
                    r_done_cnt <= r_done_cnt + CNT_BITS'(1);
                end
                r_sum_ta <= sum_ta_wide[SUM_BITS] ? '1 : sum_ta_wide[SUM_BITS-1:0];
                r_sum_wt <= sum_wt_wide[SUM_BITS] ? '1 : sum_wt_wide[SUM_BITS-1:0];
            end
        end
    end

    // Capture the best candidate
    always_ff @(posedge i_clk) begin
        if (cand_ready && cand_better) begin
            r_best     <= r_rd_data;
            r_best_idx <= r_rd_idx;
        end
    end

    // Result of the item in flight: cleared at accept, filled at update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.tick_start) begin
            r_res_chosen <= 1'b0;
            r_res_slot   <= '0;
            r_res_prio   <= '0;
            r_res_start  <= '0;
            r_res_fin    <= 1'b0;
            r_res_ta     <= '0;
            r_res_wt     <= '0;
        end else if (i_cmd.update && r_found) begin
            r_res_chosen <= 1'b1;
            r_res_slot   <= SLOT_BITS'(r_best_idx);
            r_res_prio   <= r_best.priority_lvl;
            r_res_start  <= start_sat;
            if (r_best.remaining == FIELD_BITS'(1)) begin
                r_res_fin <= 1'b1;
                r_res_ta  <= ta_sat;
                r_res_wt  <= wt_sat;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_chosen_valid     <= r_res_chosen;
            o_chosen_slot      <= r_res_slot;
            o_chosen_priority  <= r_res_prio;
            o_start_time       <= r_res_start;
            o_finished         <= r_res_fin;
            o_turnaround       <= r_res_ta;
            o_waiting          <= r_res_wt;
            o_all_done         <= (r_done_cnt >= r_piu);
            o_total_turnaround <= r_sum_ta;
            o_total_waiting    <= r_sum_wt;
        end
    end

endmodule

FILE: rtl/ppsa_checker.sv
// Port-level checks of the priority scheduler, bound to the top level.
// Depends on ppsa_pkg for field widths.
module ppsa_checker
    import ppsa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_chosen_valid,
    input logic [SLOT_BITS-1:0]  o_chosen_slot,
    input logic [PRIO_BITS-1:0]  o_chosen_priority,
    input logic [FIELD_BITS-1:0] o_start_time,
    input logic                  o_finished,
    input logic [FIELD_BITS-1:0] o_turnaround,
    input logic [FIELD_BITS-1:0] o_waiting
);

    // A result stays offered until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // One item at a time: no second transfer right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after a transfer");

    // A completion is only reported for a task that ran
    a_fin_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> o_chosen_valid)
        else $error("finished without a chosen task");

    // Idle results carry zero task fields
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chosen_valid |->
            (o_chosen_slot == '0) && (o_chosen_priority == '0) &&
            (o_start_time == '0) && !o_finished)
        else $error("task fields set on a result without a pick");

    // Waiting never exceeds turnaround
    a_wait_le_ta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_waiting <= o_turnaround))
        else $error("waiting above turnaround");

endmodule

bind preemptive_priority_scheduler_aging_core ppsa_checker u_ppsa_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench of the preemptive priority scheduler with aging: a directed table,
// then random loads and ticks, each result checked against a predictor or a typed row.
// Depends on ppsa_pkg and preemptive_priority_scheduler_aging_core.
module tb;
    import ppsa_pkg::*;

    localparam int NSLOTS = 16;
    localparam logic [FIELD_BITS-1:0] TIME_TOP = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP = 30;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic                  action;
        logic [SLOT_BITS-1:0]  slot;
        logic [FIELD_BITS-1:0] arrival;
        logic [FIELD_BITS-1:0] run_length;
        logic [PRIO_BITS-1:0]  prio;
    } sched_item_t;

    typedef struct packed {
        logic                  chosen_valid;
        logic [SLOT_BITS-1:0]  chosen_slot;
        logic [PRIO_BITS-1:0]  chosen_prio;
        logic [FIELD_BITS-1:0] start_time;
        logic                  finished;
        logic [FIELD_BITS-1:0] turnaround;
        logic [FIELD_BITS-1:0] waiting;
        logic                  all_done;
        logic [SUM_BITS-1:0]   total_turnaround;
        logic [SUM_BITS-1:0]   total_waiting;
    } sched_result_t;

    typedef struct {
        sched_item_t   item;
        bit            typed;
        sched_result_t res;
    } dir_row_t;

    localparam sched_item_t TICK_ITEM = '{ACT_TICK, '0, '0, '0, '0};

    // Clock, reset and driven inputs
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CNT_BITS-1:0] cfg_wdata = '0;
    sched_item_t drv_item = '0;
    bit drv_typed = 1'b0;
    sched_result_t drv_res = '0;

    // Outputs of the block
    logic o_in_ready, o_out_valid;
    logic o_chosen_valid, o_finished, o_all_done;
    logic [SLOT_BITS-1:0] o_chosen_slot;
    logic [PRIO_BITS-1:0] o_chosen_priority;
    logic [FIELD_BITS-1:0] o_start_time, o_turnaround, o_waiting;
    logic [SUM_BITS-1:0] o_total_turnaround, o_total_waiting;

    // Predicted scheduler state
    logic [FIELD_BITS-1:0] arr_tab [NSLOTS];
    logic [FIELD_BITS-1:0] rem_tab [NSLOTS];
    logic [FIELD_BITS-1:0] orig_tab [NSLOTS];
    logic [PRIO_BITS-1:0] prio_tab [NSLOTS];
    logic [1:0] age_tab [NSLOTS];
    logic [FIELD_BITS-1:0] now_t = '0;
    logic [CNT_BITS-1:0] done_cnt = '0;
    logic [SUM_BITS-1:0] sum_ta = '0;
    logic [SUM_BITS-1:0] sum_wt = '0;
    logic [CNT_BITS-1:0] procs_cfg = '0;

    sched_result_t pending_results [$];
    dir_row_t dir_rows [$];

    bit idle_en = 1'b1;
    bit hold_req = 1'b0;
    int errors = 0;
    int n_results = 0;
    int n_loads = 0;
    int n_ticks = 0;
    int n_idle_ticks = 0;
    int n_completions = 0;
    int n_cfg = 0;
    int n_holds = 0;
    int quiet_cycles = 0;

    preemptive_priority_scheduler_aging_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (drv_item.action),
        .i_slot             (drv_item.slot),
        .i_arrival          (drv_item.arrival),
        .i_run_length       (drv_item.run_length),
        .i_start_priority   (drv_item.prio),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_chosen_valid     (o_chosen_valid),
        .o_chosen_slot      (o_chosen_slot),
        .o_chosen_priority  (o_chosen_priority),
        .o_start_time       (o_start_time),
        .o_finished         (o_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_all_done         (o_all_done),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata)
    );

    // Free-running clock
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Advance the predicted scheduler by one item and return its result
    function automatic sched_result_t next_schedule_result(input sched_item_t it);
        sched_result_t r;
        int best;
        bit found;
        logic [FIELD_BITS-1:0] done_at, ta, wt;
        logic [SUM_BITS:0] acc;
        r = '0;
        best = 0;
        found = 1'b0;
        if (it.action == ACT_LOAD) begin
            arr_tab[it.slot] = it.arrival;
            rem_tab[it.slot] = it.run_length;
            orig_tab[it.slot] = it.run_length;
            prio_tab[it.slot] = it.prio;
            age_tab[it.slot] = '0;
        end else begin
            // pick: highest priority, then earliest arrival, then lowest slot
            for (int i = 0; i < NSLOTS; i++) begin
                if (arr_tab[i] <= now_t && rem_tab[i] != '0 &&
                    (!found || prio_tab[i] > prio_tab[best] ||
                     (prio_tab[i] == prio_tab[best] && arr_tab[i] < arr_tab[best]))) begin
                    best = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                r.chosen_valid = 1'b1;
                r.chosen_slot = best[SLOT_BITS-1:0];
                r.chosen_prio = prio_tab[best];
                r.start_time = now_t;
                rem_tab[best] = rem_tab[best] - 1'b1;
                // age on every third selection, floored at zero
                if (age_tab[best] < AGING_LIMIT) begin
                    age_tab[best] = age_tab[best] + 1'b1;
                end else begin
                    age_tab[best] = '0;
                    if (prio_tab[best] != '0)
                        prio_tab[best] = prio_tab[best] - 1'b1;
                end
                if (rem_tab[best] == '0) begin
                    done_at = (now_t < TIME_TOP) ? now_t + 1'b1 : TIME_TOP;
                    ta = done_at - arr_tab[best];
                    wt = (ta > orig_tab[best]) ? ta - orig_tab[best] : '0;
                    if (done_cnt < 5'd31)
                        done_cnt = done_cnt + 1'b1;
                    acc = {1'b0, sum_ta} + ta;
                    sum_ta = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
                    acc = {1'b0, sum_wt} + wt;
                    sum_wt = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
                    r.finished = 1'b1;
                    r.turnaround = ta;
                    r.waiting = wt;
                end
            end
            if (now_t < TIME_TOP)
                now_t = now_t + 1'b1;
        end
        r.all_done = (done_cnt >= procs_cfg);
        r.total_turnaround = sum_ta;
        r.total_waiting = sum_wt;
        return r;
    endfunction

    function automatic sched_item_t load_item(input int s, input logic [FIELD_BITS-1:0] a,
                                              input logic [FIELD_BITS-1:0] len,
                                              input logic [PRIO_BITS-1:0] p);
        sched_item_t it;
        it = '{ACT_LOAD, s[SLOT_BITS-1:0], a, len, p};
        return it;
    endfunction

    // Result of an item that ran nothing, before any completion
    function automatic sched_result_t bare_result(input logic all_done);
        sched_result_t r;
        r = '0;
        r.all_done = all_done;
        return r;
    endfunction

    // Mostly ticks and loads of short tasks arriving around the present time
    function automatic sched_item_t random_item();
        sched_item_t it;
        int pick;
        int near;
        it.action = ($urandom_range(0, 99) < 60) ? ACT_TICK : ACT_LOAD;
        it.slot = SLOT_BITS'($urandom_range(0, NSLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.arrival = FIELD_BITS'($urandom());
        end else if (pick < 20) begin
            it.arrival = '0;
        end else begin
            near = int'(now_t) + int'($urandom_range(0, 8)) - 4;
            it.arrival = (near < 0) ? '0 : FIELD_BITS'(near);
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            it.run_length = FIELD_BITS'($urandom());
        else if (pick < 12)
            it.run_length = '0;
        else
            it.run_length = FIELD_BITS'($urandom_range(1, 6));
        if ($urandom_range(0, 99) < 30)
            it.prio = PRIO_BITS'($urandom_range(0, 255));
        else
            it.prio = PRIO_BITS'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (errors < PRINT_CAP)
            $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
                     $time, n_results, what, want, got);
        errors++;
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            report_mismatch(what, want, got);
    endtask

    task automatic add_row(input sched_item_t it, input bit typed, input sched_result_t res);
        dir_row_t row;
        row.item = it;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    // Offer one item, after an occasional random gap, and hold it until the transfer
    task automatic offer(input sched_item_t it, input bit typed, input sched_result_t res);
        if (idle_en && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge i_clk);
        end
        drv_item = it;
        drv_typed = typed;
        drv_res = res;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Write the register once the block has drained
    task automatic write_procs(input logic [CNT_BITS-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        procs_cfg = v;
        n_cfg++;
    endtask

    // Predict on every input transfer
    always @(posedge i_clk) begin
        sched_result_t r;
        if (rst_n && in_valid && o_in_ready) begin
            r = next_schedule_result(drv_item);
            pending_results.push_back(drv_typed ? drv_res : r);
            if (drv_item.action == ACT_LOAD) begin
                n_loads++;
            end else begin
                n_ticks++;
                if (!r.chosen_valid)
                    n_idle_ticks++;
                if (r.finished)
                    n_completions++;
            end
        end
    end

    // Compare every output transfer with the oldest prediction
    always @(posedge i_clk) begin
        sched_result_t got, want;
        if (rst_n && o_out_valid && out_ready) begin
            n_results++;
            got = '{o_chosen_valid, o_chosen_slot, o_chosen_priority, o_start_time,
                    o_finished, o_turnaround, o_waiting, o_all_done,
                    o_total_turnaround, o_total_waiting};
            if (pending_results.size() == 0) begin
                report_mismatch("arrived with nothing pending", 0, got.chosen_slot);
            end else begin
                want = pending_results.pop_front();
                check_field("chosen_valid", want.chosen_valid, got.chosen_valid);
                check_field("chosen_slot", want.chosen_slot, got.chosen_slot);
                check_field("chosen_priority", want.chosen_prio, got.chosen_prio);
                check_field("start_time", want.start_time, got.start_time);
                check_field("finished", want.finished, got.finished);
                check_field("turnaround", want.turnaround, got.turnaround);
                check_field("waiting", want.waiting, got.waiting);
                check_field("all_done", want.all_done, got.all_done);
                check_field("total_turnaround", want.total_turnaround, got.total_turnaround);
                check_field("total_waiting", want.total_waiting, got.total_waiting);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end else begin
                out_ready <= !(idle_en && $urandom_range(0, 99) < 11);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!rst_n || cfg_we || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus
    initial begin
        sched_result_t no_result;
        logic [CNT_BITS-1:0] procs_list [4];
        no_result = '0;
        procs_list = '{5'd16, 5'd31, 5'd3, 5'd9};
        for (int i = 0; i < NSLOTS; i++) begin
            arr_tab[i] = '0;
            rem_tab[i] = '0;
            orig_tab[i] = '0;
            prio_tab[i] = '0;
            age_tab[i] = '0;
        end

        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed: idle tick, extremes, ties, aging, zero length, reload, late arrival
        write_procs(5'd0);
        add_row(TICK_ITEM, 1'b1, bare_result(1'b1));
        add_row(load_item(0, 16'd0, 16'd1, 8'd255), 1'b1, bare_result(1'b1));
        add_row(load_item(15, 16'hFFFF, 16'hFFFF, 8'd255), 1'b1, bare_result(1'b1));
        add_row(load_item(4, 16'd0, 16'd0, 8'd200), 1'b1, bare_result(1'b1));
        add_row(TICK_ITEM, 1'b0, no_result);
        add_row(load_item(1, 16'd2, 16'd3, 8'd5), 1'b0, no_result);
        add_row(load_item(2, 16'd2, 16'd3, 8'd5), 1'b0, no_result);
        add_row(load_item(3, 16'd0, 16'd2, 8'd5), 1'b0, no_result);
        repeat (4) add_row(TICK_ITEM, 1'b0, no_result);
        add_row(load_item(1, 16'd0, 16'd4, 8'd0), 1'b0, no_result);
        repeat (3) add_row(TICK_ITEM, 1'b0, no_result);
        add_row(load_item(5, 16'd200, 16'd1, 8'd255), 1'b0, no_result);
        repeat (6) add_row(TICK_ITEM, 1'b0, no_result);
        foreach (dir_rows[i])
            offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

        // Random phases under several register settings; one without idling
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3)
                procs_list[ph] = CNT_BITS'($urandom_range(1, 15));
            write_procs(procs_list[ph]);
            idle_en = (ph != 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 60)
                    hold_req = 1'b1;
                offer(random_item(), 1'b0, no_result);
            end
        end

        // Drain and report
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Run covered %0d loads, %0d ticks (%0d idle, %0d completions), %0d results.",
                 n_loads, n_ticks, n_idle_ticks, n_completions, n_results);
        $display("%0d register writes, %0d receiver hold-offs, time reached %0d, %0d mismatches.",
                 n_cfg, n_holds, now_t, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
